@@ design/txcon_pkg.sv @@
// Shared constants, command and status types for the text console line writer.
package txcon_pkg;

  // Default geometry of the external line ring.
  localparam int unsigned ROWS_DEF      = 256;
  localparam int unsigned COLUMNS_DEF   = 64;
  localparam int unsigned TAB_WIDTH_DEF = 4;

  // Fixed field widths of the result transaction.
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned COL_W   = 6;
  localparam int unsigned COUNT_W = 32;

  // Character codes with a meaning of their own.
  localparam logic [CHAR_W-1:0] CH_NULL    = 8'd0;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  // Datapath operations issued by the controller.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_NEWROW,
    OP_GLYPH,
    OP_SPACE
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic is_null;
    logic is_newline;
    logic is_tab;
    logic line_full;
    logic tab_last;
    logic out_busy;
  } status_t;

endpackage

@@ design/txcon_ctrl.sv @@
// Controller state machine: accepts characters and sequences tab expansion.
module txcon_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  txcon_pkg::status_t status,
  output txcon_pkg::cmd_t    cmd
);
  import txcon_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TAB  = 1'b1;

  logic state_r;
  logic state_nxt;
  logic slot_free;

  // The output register can take a new result when empty or being drained.
  assign slot_free = !status.out_busy;

  // Decide the operation, the next state and the input stall.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = !slot_free;
        if (in_valid && slot_free) begin
          priority if (status.is_null) begin
            cmd.op = OP_NONE;
          end else if (status.is_newline || status.line_full) begin
            cmd.op = OP_NEWROW;
          end else if (status.is_tab) begin
            cmd.op = OP_SPACE;
            if (!status.tab_last) begin
              state_nxt = ST_TAB;
            end
          end else begin
            cmd.op = OP_GLYPH;
          end
        end
      end
      ST_TAB: begin
        if (slot_free) begin
          cmd.op = OP_SPACE;
          if (status.tab_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/txcon_datapath.sv @@
// Datapath: row counter, line length, tab phase, follow row and result register.
module txcon_datapath #(
  parameter int unsigned ROWS      = txcon_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS   = txcon_pkg::COLUMNS_DEF,
  parameter int unsigned TAB_WIDTH = txcon_pkg::TAB_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [txcon_pkg::CHAR_W-1:0]       in_char_code,
  input  txcon_pkg::cmd_t                    cmd,
  output txcon_pkg::status_t                 status,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [txcon_pkg::SLOT_W-1:0]       out_row_slot,
  output logic [txcon_pkg::COL_W-1:0]        out_column,
  output logic [txcon_pkg::CHAR_W-1:0]       out_glyph,
  output logic                               out_write_glyph,
  output logic                               out_clear_line,
  output logic [txcon_pkg::COUNT_W-1:0]      out_total_rows,
  output logic [txcon_pkg::COUNT_W-1:0]      out_follow_row,
  output logic                               out_last
);
  import txcon_pkg::*;

  localparam int unsigned SW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned LW = $clog2(COLUMNS + 1);
  localparam int unsigned PW = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  // Tab phase after one character has been placed on a fresh line.
  localparam logic [PW-1:0] PHASE_ONE = (TAB_WIDTH > 1) ? PW'(1) : PW'(0);

  logic [COUNT_W-1:0] row_cnt_r;
  logic [COUNT_W-1:0] aim_r;
  logic [SW-1:0]      slot_r;
  logic [LW-1:0]      len_r;
  logic [PW-1:0]      phase_r;
  logic               out_valid_r;

  logic [COUNT_W-1:0] row_cnt_inc;
  logic [COUNT_W-1:0] aim_nxt;
  logic [SW-1:0]      slot_inc;
  logic [LW-1:0]      len_inc;
  logic [PW-1:0]      phase_inc;
  logic               is_newline;

  // Incremented values; the slot and the tab phase wrap at their moduli.
  // The slot also restarts when the row counter itself wraps to zero.
  assign row_cnt_inc = row_cnt_r + COUNT_W'(1);
  assign slot_inc    = ((slot_r == SW'(ROWS - 1)) || (row_cnt_inc == '0)) ? '0 :
                       slot_r + SW'(1);
  assign len_inc     = len_r + LW'(1);
  assign phase_inc   = (phase_r == PW'(TAB_WIDTH - 1)) ? '0 : phase_r + PW'(1);
  // The follow row moves only when it was level with the row counter.
  assign aim_nxt     = (row_cnt_r == aim_r) ? row_cnt_inc : aim_r;
  assign is_newline  = (in_char_code == CH_NEWLINE);

  // Status towards the controller.
  always_comb begin
    status.is_null    = (in_char_code == CH_NULL);
    status.is_newline = is_newline;
    status.is_tab     = (in_char_code == CH_TAB);
    status.line_full  = (len_r == LW'(COLUMNS));
    status.tab_last   = (phase_inc == '0) || (len_inc == LW'(COLUMNS));
    status.out_busy   = out_valid_r && out_stall;
  end

  // Line state and the output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r   <= '0;
      aim_r       <= '0;
      slot_r      <= '0;
      len_r       <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_NEWROW: begin
          row_cnt_r <= row_cnt_inc;
          aim_r     <= aim_nxt;
          slot_r    <= slot_inc;
          len_r     <= is_newline ? LW'(0) : LW'(1);
          phase_r   <= is_newline ? PW'(0) : PHASE_ONE;
        end
        OP_GLYPH, OP_SPACE: begin
          len_r   <= len_inc;
          phase_r <= phase_inc;
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase
      if (cmd.op != OP_NONE) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded whenever an operation issues a write.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_NEWROW: begin
        out_row_slot    <= SLOT_W'(slot_inc);
        out_column      <= '0;
        out_glyph       <= is_newline ? CH_NULL : in_char_code;
        out_write_glyph <= !is_newline;
        out_clear_line  <= 1'b1;
        out_total_rows  <= row_cnt_inc;
        out_follow_row  <= aim_nxt;
        out_last        <= 1'b1;
      end
      OP_GLYPH, OP_SPACE: begin
        out_row_slot    <= SLOT_W'(slot_r);
        out_column      <= COL_W'(len_r);
        out_glyph       <= (cmd.op == OP_SPACE) ? CH_SPACE : in_char_code;
        out_write_glyph <= 1'b1;
        out_clear_line  <= 1'b0;
        out_total_rows  <= row_cnt_r;
        out_follow_row  <= aim_r;
        out_last        <= (cmd.op == OP_SPACE) ? status.tab_last : 1'b1;
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ design/text_console_line_writer_top.sv @@
// A result appears in the output register in the cycle after its character is accepted.
// Throughput: one character per cycle while the output is not stalled; after a tab, further input
// stalls until its last space has issued, since all spaces leave through the single output register.
// A null byte is accepted and yields no result.
// Reset (synchronous, rst_n low) clears the row counter, line length, tab phase, follow row
// and the output valid flag.
module text_console_line_writer_top #(
  parameter int unsigned ROWS      = txcon_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS   = txcon_pkg::COLUMNS_DEF,
  parameter int unsigned TAB_WIDTH = txcon_pkg::TAB_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [txcon_pkg::CHAR_W-1:0]       in_char_code,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [txcon_pkg::SLOT_W-1:0]       out_row_slot,
  output logic [txcon_pkg::COL_W-1:0]        out_column,
  output logic [txcon_pkg::CHAR_W-1:0]       out_glyph,
  output logic                               out_write_glyph,
  output logic                               out_clear_line,
  output logic [txcon_pkg::COUNT_W-1:0]      out_total_rows,
  output logic [txcon_pkg::COUNT_W-1:0]      out_follow_row,
  output logic                               out_last
);
  import txcon_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Controller.
  txcon_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  txcon_datapath #(
    .ROWS      (ROWS),
    .COLUMNS   (COLUMNS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_char_code    (in_char_code),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_slot    (out_row_slot),
    .out_column      (out_column),
    .out_glyph       (out_glyph),
    .out_write_glyph (out_write_glyph),
    .out_clear_line  (out_clear_line),
    .out_total_rows  (out_total_rows),
    .out_follow_row  (out_follow_row),
    .out_last        (out_last)
  );

  // Any issued operation presents a result transaction in the next cycle.
  a_op_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op != OP_NONE) |=> out_valid)
    else $error("issued operation produced no result");

  // An accepted newline yields a lone clear of the new line.
  a_newline_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_char_code == CH_NEWLINE) |=>
      (out_valid && out_clear_line && !out_write_glyph && out_last))
    else $error("newline did not produce a single line clear");

  // A cleared line is always written from its first column.
  a_clear_at_col0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clear_line) |-> (out_column == '0))
    else $error("line clear away from column zero");

  // A result without a glyph is only ever a line clear.
  a_noglyph_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_glyph) |-> out_clear_line)
    else $error("result with neither glyph nor clear");

endmodule

@@ tb/text_console_line_writer_checker.sv @@
// Scoreboard for the text console line writer: predicts line writes and compares them.
module text_console_line_writer_checker #(
  parameter int unsigned ROWS      = txcon_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS   = txcon_pkg::COLUMNS_DEF,
  parameter int unsigned TAB_WIDTH = txcon_pkg::TAB_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [txcon_pkg::CHAR_W-1:0]  in_char_code,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [txcon_pkg::SLOT_W-1:0]  out_row_slot,
  input  logic [txcon_pkg::COL_W-1:0]   out_column,
  input  logic [txcon_pkg::CHAR_W-1:0]  out_glyph,
  input  logic                          out_write_glyph,
  input  logic                          out_clear_line,
  input  logic [txcon_pkg::COUNT_W-1:0] out_total_rows,
  input  logic [txcon_pkg::COUNT_W-1:0] out_follow_row,
  input  logic                          out_last,
  output int unsigned                   mismatches,
  output int unsigned                   pending,
  output int unsigned                   chars_seen,
  output int unsigned                   tabs_seen,
  output int unsigned                   newlines_seen,
  output int unsigned                   wraps_seen,
  output int unsigned                   writes_checked
);
  import txcon_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0]  row_slot;
    logic [COL_W-1:0]   column;
    logic [CHAR_W-1:0]  glyph;
    logic               write_glyph;
    logic               clear_line;
    logic [COUNT_W-1:0] total_rows;
    logic [COUNT_W-1:0] follow_row;
    logic               last;
  } line_write_t;

  // Predicted console state.
  logic [COUNT_W-1:0] row_count;
  logic [COUNT_W-1:0] aim_row;
  int unsigned        line_len;

  line_write_t expected_writes[$];

  int unsigned fail_count;
  int unsigned n_chars;
  int unsigned n_tabs;
  int unsigned n_newlines;
  int unsigned n_wraps;
  int unsigned n_writes;

  // Counts a mismatch and prints a line for it.
  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] line write mismatch: %s", $time, what);
  endtask

  // Builds one line write against the row counter and follow row as they now stand.
  function automatic line_write_t make_write(input int unsigned col,
                                             input logic [CHAR_W-1:0] ch,
                                             input logic wr, input logic clr,
                                             input logic is_last);
    line_write_t w;
    w.row_slot    = SLOT_W'(row_count % ROWS);
    w.column      = COL_W'(col);
    w.glyph       = ch;
    w.write_glyph = wr;
    w.clear_line  = clr;
    w.total_rows  = row_count;
    w.follow_row  = aim_row;
    w.last        = is_last;
    return w;
  endfunction

  // Advances the predicted console by one character and queues the writes it causes.
  task automatic predict_writes(input logic [CHAR_W-1:0] ch);
    int unsigned spaces;
    int unsigned room;
    int unsigned i;
    if (ch == CH_NULL) return;
    n_chars++;
    if (ch == CH_NEWLINE || line_len >= COLUMNS) begin
      // A new row starts: the counter moves on and the follow row keeps up if it was level with it.
      row_count = row_count + 32'd1;
      if (row_count == aim_row + 32'd1) aim_row = row_count;
      if (ch == CH_NEWLINE) begin
        n_newlines++;
        line_len = 0;
        expected_writes.push_back(make_write(0, CH_NULL, 1'b0, 1'b1, 1'b1));
      end else begin
        // The overflowing byte opens the new row, a tab included.
        n_wraps++;
        line_len = 1;
        expected_writes.push_back(make_write(0, ch, 1'b1, 1'b1, 1'b1));
      end
    end else if (ch == CH_TAB) begin
      // Spaces up to the next tab stop, never beyond the end of the line.
      n_tabs++;
      spaces = TAB_WIDTH - line_len % TAB_WIDTH;
      room   = COLUMNS - line_len;
      if (spaces > room) spaces = room;
      for (i = 0; i < spaces; i++) begin
        expected_writes.push_back(make_write(line_len, CH_SPACE, 1'b1, 1'b0, i == spaces - 1));
        line_len++;
      end
    end else begin
      expected_writes.push_back(make_write(line_len, ch, 1'b1, 1'b0, 1'b1));
      line_len++;
    end
  endtask

  // Predicts on every accepted character and checks every accepted line write.
  always @(posedge clk) begin : monitor
    line_write_t got;
    line_write_t want;
    if (!rst_n) begin
      row_count = '0;
      aim_row   = '0;
      line_len  = 0;
      expected_writes.delete();
    end else begin
      if (in_valid && !in_stall) predict_writes(in_char_code);
      if (out_valid && !out_stall) begin
        got.row_slot    = out_row_slot;
        got.column      = out_column;
        got.glyph       = out_glyph;
        got.write_glyph = out_write_glyph;
        got.clear_line  = out_clear_line;
        got.total_rows  = out_total_rows;
        got.follow_row  = out_follow_row;
        got.last        = out_last;
        n_writes++;
        if (expected_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction slot %0d column %0d glyph 0x%0h",
                                    got.row_slot, got.column, got.glyph));
        end else begin
          want = expected_writes.pop_front();
          if (got.row_slot !== want.row_slot)
            report_mismatch($sformatf("row_slot expected %0d got %0d",
                                      want.row_slot, got.row_slot));
          if (got.column !== want.column)
            report_mismatch($sformatf("column expected %0d got %0d", want.column, got.column));
          if (got.glyph !== want.glyph)
            report_mismatch($sformatf("glyph expected 0x%0h got 0x%0h", want.glyph, got.glyph));
          if (got.write_glyph !== want.write_glyph)
            report_mismatch($sformatf("write_glyph expected %0b got %0b",
                                      want.write_glyph, got.write_glyph));
          if (got.clear_line !== want.clear_line)
            report_mismatch($sformatf("clear_line expected %0b got %0b",
                                      want.clear_line, got.clear_line));
          if (got.total_rows !== want.total_rows)
            report_mismatch($sformatf("total_rows expected %0d got %0d",
                                      want.total_rows, got.total_rows));
          if (got.follow_row !== want.follow_row)
            report_mismatch($sformatf("follow_row expected %0d got %0d",
                                      want.follow_row, got.follow_row));
          if (got.last !== want.last)
            report_mismatch($sformatf("last expected %0b got %0b", want.last, got.last));
        end
      end
    end
    mismatches     <= fail_count;
    pending        <= expected_writes.size();
    chars_seen     <= n_chars;
    tabs_seen      <= n_tabs;
    newlines_seen  <= n_newlines;
    wraps_seen     <= n_wraps;
    writes_checked <= n_writes;
  end

  initial begin
    fail_count = 0;
    n_chars    = 0;
    n_tabs     = 0;
    n_newlines = 0;
    n_wraps    = 0;
    n_writes   = 0;
    row_count  = '0;
    aim_row    = '0;
    line_len   = 0;
  end

endmodule

@@ tb/text_console_line_writer_top_tb.sv @@
// Testbench top for the text console line writer: stimulus, receiver, watchdog and verdict.
module text_console_line_writer_top_tb;
  import txcon_pkg::*;

  localparam int unsigned ROWS         = ROWS_DEF;
  localparam int unsigned COLUMNS      = COLUMNS_DEF;
  localparam int unsigned TAB_WIDTH    = TAB_WIDTH_DEF;
  localparam int unsigned RANDOM_CHARS = 355;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_LIMIT   = 3000;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic [CHAR_W-1:0]  in_char_code = '0;
  logic               out_stall    = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [SLOT_W-1:0]  out_row_slot;
  logic [COL_W-1:0]   out_column;
  logic [CHAR_W-1:0]  out_glyph;
  logic               out_write_glyph;
  logic               out_clear_line;
  logic [COUNT_W-1:0] out_total_rows;
  logic [COUNT_W-1:0] out_follow_row;
  logic               out_last;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned chars_seen;
  int unsigned tabs_seen;
  int unsigned newlines_seen;
  int unsigned wraps_seen;
  int unsigned writes_checked;

  // Pacing controls of the sender and the receiver.
  bit          fast_send    = 1'b0;
  bit          fast_take    = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned drains       = 0;
  int unsigned idle_cycles  = 0;

  text_console_line_writer_top #(
    .ROWS      (ROWS),
    .COLUMNS   (COLUMNS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_slot    (out_row_slot),
    .out_column      (out_column),
    .out_glyph       (out_glyph),
    .out_write_glyph (out_write_glyph),
    .out_clear_line  (out_clear_line),
    .out_total_rows  (out_total_rows),
    .out_follow_row  (out_follow_row),
    .out_last        (out_last)
  );

  text_console_line_writer_checker #(
    .ROWS      (ROWS),
    .COLUMNS   (COLUMNS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_slot    (out_row_slot),
    .out_column      (out_column),
    .out_glyph       (out_glyph),
    .out_write_glyph (out_write_glyph),
    .out_clear_line  (out_clear_line),
    .out_total_rows  (out_total_rows),
    .out_follow_row  (out_follow_row),
    .out_last        (out_last),
    .mismatches      (mismatches),
    .pending         (pending),
    .chars_seen      (chars_seen),
    .tabs_seen       (tabs_seen),
    .newlines_seen   (newlines_seen),
    .wraps_seen      (wraps_seen),
    .writes_checked  (writes_checked)
  );

  // Clock generation.
  initial begin
    forever #4 clk = ~clk;
  end

  // Offers one character after a random gap (none when fast_send is set) and waits until its transaction completes.
  task automatic offer_char(input logic [CHAR_W-1:0] ch);
    int unsigned gap;
    gap = fast_send ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= ch;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops sending until every predicted line write has been taken.
  task automatic drain_writes();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    drains++;
  endtask

  // Draws a character: mostly printable text, some tabs and newlines, now and then any non-null byte.
  function automatic logic [CHAR_W-1:0] draw_char(input int unsigned newline_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < newline_pct) return CH_NEWLINE;
    if (roll < newline_pct + 12) return CH_TAB;
    if (roll < 75) return CHAR_W'($urandom_range(32, 126));
    return CHAR_W'($urandom_range(1, 255));
  endfunction

  // Receiver: stalls a random number of cycles before each transaction unless fast_take is set, once for a long spell.
  initial begin : write_taker
    int unsigned hold;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_CYCLES;
      end else if (fast_take) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 19);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: ends the run when neither channel completes a transaction for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("text_console_line_writer_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int unsigned sent;
    int unsigned seg;
    int unsigned seg_len;
    int unsigned newline_pct;
    int unsigned k;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: extreme bytes, a tab mid-stop, a null, a line filled by tabs,
    // a null on the full line, an overflowing tab, blank lines and a tab from column zero.
    offer_char(8'h41);
    offer_char(CH_TAB);
    offer_char(8'hFF);
    offer_char(8'h01);
    offer_char(8'h80);
    offer_char(8'h7F);
    offer_char(CH_NULL);
    repeat (14) offer_char(CH_TAB);
    offer_char(CH_NULL);
    offer_char(CH_TAB);
    offer_char(CH_NEWLINE);
    offer_char(CH_NEWLINE);
    offer_char(CH_TAB);
    drain_writes();

    // Random text in segments; some segments carry no newlines so that lines overflow.
    sent = 0;
    seg  = 0;
    while (sent < RANDOM_CHARS) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0:       newline_pct = 0;
        1:       newline_pct = 3;
        default: newline_pct = 10;
      endcase
      fast_send = ($urandom_range(0, 3) == 0);
      fast_take = ($urandom_range(0, 3) == 0);
      if (seg == 1) begin
        // Long receiver hold-off while the sender keeps pushing back to back.
        hold_off_req = 1'b1;
        fast_send    = 1'b1;
        seg_len      = 40;
      end
      if (seg == 4) drain_writes();
      for (k = 0; k < seg_len && sent < RANDOM_CHARS; k++) begin
        offer_char(draw_char(newline_pct));
        sent++;
      end
      seg++;
    end

    drain_writes();
    repeat (8) @(posedge clk);

    $display("Covered %0d characters: %0d tabs, %0d newlines, %0d full-line wraps; %0d writes.",
             chars_seen, tabs_seen, newlines_seen, wraps_seen, writes_checked);
    $display("Receiver held off %0d cycles once; sender waited for an empty pipe %0d times.",
             HOLD_CYCLES, drains);
    if (mismatches == 0 && pending == 0) begin
      $display("text_console_line_writer_top verification clean");
    end else begin
      $display("text_console_line_writer_top verification failed");
    end
    $finish;
  end

endmodule
